>>> rtl/priority_ready_list_manager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority ready list manager
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_LIST_MANAGER_ASSERT_SVH
`define PRIORITY_READY_LIST_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS

// a in one cycle implies b in the same cycle
`define PRLM_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed: implication");

// a in one cycle implies b in the next cycle
`define PRLM_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`else

`define PRLM_ASSERT_IMPL(lbl, clk, rstn, a, b)
`define PRLM_ASSERT_NEXT(lbl, clk, rstn, a, b)

`endif

`endif

>>> rtl/prlm_pkg.sv
// ----------------------------------------------------------------------------
// prlm_pkg
// Types and constants shared by the ready list manager modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prlm_pkg;

  localparam logic [6:0] NO_TASK = 7'd64;

  localparam logic [2:0] CMD_INS_AUTO = 3'd0;
  localparam logic [2:0] CMD_INS_HEAD = 3'd1;
  localparam logic [2:0] CMD_INS_TAIL = 3'd2;
  localparam logic [2:0] CMD_REMOVE   = 3'd3;
  localparam logic [2:0] CMD_ROTATE   = 3'd4;
  localparam logic [2:0] CMD_SCHED    = 3'd5;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_QUEUED = 2'd1;
  localparam logic [1:0] STS_NOTQ   = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] task_id;
    logic [4:0] task_prio;
    logic [4:0] current_prio;
    logic [6:0] current_task;
  } in_t;

  typedef struct packed {
    logic [6:0] next_task;
    logic [4:0] next_prio;
    logic       switch_needed;
    logic [1:0] status;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TWAIT,
    ST_LWAIT,
    ST_NWAIT,
    ST_WR1,
    ST_WR2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_REM,
    OP_ROT,
    OP_SCH
  } op_t;

  typedef struct packed {
    logic acc;
    logic disp;
    logic tcap;
    logic lcap;
    logic ncap;
    logic wr1;
    logic wr2;
    logic res;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_lt2;
    logic cnt_zero;
  } dp_sts_t;

endpackage

>>> rtl/prlm_ram.sv
// ----------------------------------------------------------------------------
// prlm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

>>> rtl/prlm_ctrl.sv
// ----------------------------------------------------------------------------
// prlm_ctrl
// Command sequencer: reads, link writes and result strobe per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_ready_list_manager_assert.svh"

module prlm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  prlm_pkg::dp_sts_t  sts,
  output prlm_pkg::ctl_cmd_t cmd
);

  prlm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prlm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prlm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = prlm_pkg::ST_DISPATCH;
        end
      end
      prlm_pkg::ST_DISPATCH: begin
        if (sts.op == prlm_pkg::OP_NONE) begin
          state_nxt = prlm_pkg::ST_DONE;
        end else if (sts.op == prlm_pkg::OP_REM) begin
          state_nxt = prlm_pkg::ST_TWAIT;
        end else begin
          state_nxt = prlm_pkg::ST_LWAIT;
        end
      end
      prlm_pkg::ST_TWAIT: state_nxt = prlm_pkg::ST_LWAIT;
      prlm_pkg::ST_LWAIT: begin
        priority if (sts.op == prlm_pkg::OP_SCH) begin
          state_nxt = prlm_pkg::ST_DONE;
        end else if (sts.op == prlm_pkg::OP_ROT) begin
          state_nxt = sts.cnt_lt2 ? prlm_pkg::ST_DONE : prlm_pkg::ST_NWAIT;
        end else begin
          state_nxt = prlm_pkg::ST_WR1;
        end
      end
      prlm_pkg::ST_NWAIT: state_nxt = prlm_pkg::ST_WR1;
      prlm_pkg::ST_WR1: begin
        if ((sts.op == prlm_pkg::OP_INS && !sts.cnt_zero) || sts.op == prlm_pkg::OP_ROT) begin
          state_nxt = prlm_pkg::ST_WR2;
        end else begin
          state_nxt = prlm_pkg::ST_DONE;
        end
      end
      prlm_pkg::ST_WR2: state_nxt = prlm_pkg::ST_DONE;
      prlm_pkg::ST_DONE: state_nxt = prlm_pkg::ST_IDLE;
      default: state_nxt = prlm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != prlm_pkg::ST_IDLE);
    cmd      = '0;
    cmd.acc  = (state_r == prlm_pkg::ST_IDLE) && start;
    cmd.disp = (state_r == prlm_pkg::ST_DISPATCH);
    cmd.tcap = (state_r == prlm_pkg::ST_TWAIT);
    cmd.lcap = (state_r == prlm_pkg::ST_LWAIT);
    cmd.ncap = (state_r == prlm_pkg::ST_NWAIT);
    cmd.wr1  = (state_r == prlm_pkg::ST_WR1);
    cmd.wr2  = (state_r == prlm_pkg::ST_WR2);
    cmd.res  = (state_r == prlm_pkg::ST_DONE);
  end

  `PRLM_ASSERT_NEXT(a_acc_disp, clk, rst_n, cmd.acc, state_r == prlm_pkg::ST_DISPATCH)
  `PRLM_ASSERT_IMPL(a_wr2_after_wr1, clk, rst_n, state_r == prlm_pkg::ST_WR2, $past(state_r) == prlm_pkg::ST_WR1)
  `PRLM_ASSERT_NEXT(a_done_idle, clk, rst_n, state_r == prlm_pkg::ST_DONE, state_r == prlm_pkg::ST_IDLE)

endmodule

>>> rtl/prlm_dp.sv
// ----------------------------------------------------------------------------
// prlm_dp
// Datapath: link and list RAMs, ready bitmap, queued flags, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlm_dp #(
  parameter int PRIO_LEVELS = 32,
  parameter int MAX_TASKS   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prlm_pkg::in_t      in_data,
  input  prlm_pkg::ctl_cmd_t cmd,
  output prlm_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output prlm_pkg::out_t     out_data
);

  localparam int LVL_DEPTH  = (PRIO_LEVELS < 32) ? PRIO_LEVELS : 32;
  localparam int LAW        = $clog2(LVL_DEPTH);
  localparam int TASK_DEPTH = (MAX_TASKS < 64) ? MAX_TASKS : 64;
  localparam int TAW        = $clog2(TASK_DEPTH);
  localparam int CW         = $clog2(TASK_DEPTH + 1);
  localparam int LW         = 14 + CW;

  prlm_pkg::in_t   in_r;
  prlm_pkg::op_t   op_r, op_c;
  logic [1:0]      st_r, st_c;
  logic            any_r;
  logic [4:0]      prio_r, enc;
  logic [LAW-1:0]  lst_a_r, lst_raddr;
  logic [6:0]      h_r, t_r, p_r, n_r;
  logic [CW-1:0]   c_r;
  logic [LVL_DEPTH-1:0]  bitmap_r;
  logic [TASK_DEPTH-1:0] queued_r;
  prlm_pkg::out_t  out_r;
  logic            out_valid_r;

  logic            id_ok, lv_ok, queued, at_tail;
  logic [TAW-1:0]  id_a;
  logic [LAW-1:0]  lv_a;
  logic [6:0]      id7;

  logic [LW-1:0]   lst_rd, lst_wd;
  logic            lst_we;
  logic [6:0]      lh, lt;
  logic [CW-1:0]   lc;
  logic            lst_vld;

  logic [6:0]      nxt_rd, prv_rd, nxt_wd, prv_wd;
  logic [4:0]      lvl_rd;
  logic            nxt_we, prv_we, lvl_we;
  logic [TAW-1:0]  nxt_wa, prv_wa, nxt_ra;

  logic [6:0]      res_task;

  assign id_ok   = {1'b0, in_r.task_id} < 7'(TASK_DEPTH);
  assign lv_ok   = {1'b0, in_r.task_prio} < 6'(LVL_DEPTH);
  assign id_a    = in_r.task_id[TAW-1:0];
  assign lv_a    = in_r.task_prio[LAW-1:0];
  assign id7     = {1'b0, in_r.task_id};
  assign queued  = id_ok && queued_r[id_a];
  assign at_tail = (in_r.cmd == prlm_pkg::CMD_INS_TAIL) ||
                   (in_r.cmd == prlm_pkg::CMD_INS_AUTO && in_r.task_prio == in_r.current_prio);

  always_comb begin
    op_c = prlm_pkg::OP_NONE;
    st_c = prlm_pkg::STS_OK;
    unique case (in_r.cmd)
      prlm_pkg::CMD_INS_AUTO, prlm_pkg::CMD_INS_HEAD, prlm_pkg::CMD_INS_TAIL: begin
        priority if (!id_ok) begin
          st_c = prlm_pkg::STS_NOTQ;
        end else if (queued) begin
          st_c = prlm_pkg::STS_QUEUED;
        end else if (lv_ok) begin
          op_c = prlm_pkg::OP_INS;
        end
      end
      prlm_pkg::CMD_REMOVE: begin
        if (!queued) begin
          st_c = prlm_pkg::STS_NOTQ;
        end else begin
          op_c = prlm_pkg::OP_REM;
        end
      end
      prlm_pkg::CMD_ROTATE: begin
        if (lv_ok) begin
          op_c = prlm_pkg::OP_ROT;
        end
      end
      prlm_pkg::CMD_SCHED: op_c = prlm_pkg::OP_SCH;
      default: op_c = prlm_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    enc = '0;
    for (int i = LVL_DEPTH - 1; i >= 0; i--) begin
      if (bitmap_r[i]) begin
        enc = 5'(i);
      end
    end
  end

  // list RAM word: head, tail, count; a level with a clear bitmap bit is empty
  assign lst_vld = bitmap_r[lst_a_r];
  assign lh = lst_vld ? lst_rd[LW-1 -: 7] : prlm_pkg::NO_TASK;
  assign lt = lst_vld ? lst_rd[LW-8 -: 7] : prlm_pkg::NO_TASK;
  assign lc = lst_vld ? lst_rd[CW-1:0] : '0;

  always_comb begin
    priority if (cmd.disp) begin
      lst_raddr = (op_c == prlm_pkg::OP_SCH) ? enc[LAW-1:0] : lv_a;
    end else if (cmd.tcap) begin
      lst_raddr = lvl_rd[LAW-1:0];
    end else begin
      lst_raddr = lst_a_r;
    end
  end

  assign nxt_ra = cmd.lcap ? lh[TAW-1:0] : id_a;

  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = id_a;
    nxt_wd = prlm_pkg::NO_TASK;
    prv_we = 1'b0;
    prv_wa = id_a;
    prv_wd = prlm_pkg::NO_TASK;
    lvl_we = 1'b0;
    lst_we = 1'b0;
    lst_wd = {h_r, t_r, c_r};
    if (cmd.wr1) begin
      unique case (op_r)
        prlm_pkg::OP_INS: begin
          nxt_we = 1'b1;
          nxt_wd = (at_tail || c_r == '0) ? prlm_pkg::NO_TASK : h_r;
          prv_we = 1'b1;
          prv_wd = (!at_tail || c_r == '0) ? prlm_pkg::NO_TASK : t_r;
          lvl_we = 1'b1;
          lst_we = 1'b1;
          lst_wd = {(at_tail && c_r != '0) ? h_r : id7,
                    (!at_tail && c_r != '0) ? t_r : id7,
                    CW'(c_r + 1'b1)};
        end
        prlm_pkg::OP_REM: begin
          nxt_we = !p_r[6];
          nxt_wa = p_r[TAW-1:0];
          nxt_wd = n_r;
          prv_we = !n_r[6];
          prv_wa = n_r[TAW-1:0];
          prv_wd = p_r;
          lst_we = 1'b1;
          lst_wd = {p_r[6] ? n_r : h_r, n_r[6] ? p_r : t_r, CW'(c_r - 1'b1)};
        end
        prlm_pkg::OP_ROT: begin
          nxt_we = 1'b1;
          nxt_wa = h_r[TAW-1:0];
          prv_we = 1'b1;
          prv_wa = n_r[TAW-1:0];
          lst_we = 1'b1;
          lst_wd = {n_r, h_r, c_r};
        end
        default: ;
      endcase
    end else if (cmd.wr2) begin
      if (op_r == prlm_pkg::OP_ROT) begin
        nxt_we = 1'b1;
        nxt_wa = t_r[TAW-1:0];
        nxt_wd = h_r;
        prv_we = 1'b1;
        prv_wa = h_r[TAW-1:0];
        prv_wd = t_r;
      end else if (at_tail) begin
        nxt_we = 1'b1;
        nxt_wa = t_r[TAW-1:0];
        nxt_wd = id7;
      end else begin
        prv_we = 1'b1;
        prv_wa = h_r[TAW-1:0];
        prv_wd = id7;
      end
    end
  end

  prlm_ram #(.WIDTH(LW), .DEPTH(LVL_DEPTH)) u_lst_ram (
    .clk     (clk),
    .we      (lst_we),
    .waddr   (lst_a_r),
    .wdata   (lst_wd),
    .raddr   (lst_raddr),
    .rdata_r (lst_rd)
  );

  prlm_ram #(.WIDTH(7), .DEPTH(TASK_DEPTH)) u_nxt_ram (
    .clk     (clk),
    .we      (nxt_we),
    .waddr   (nxt_wa),
    .wdata   (nxt_wd),
    .raddr   (nxt_ra),
    .rdata_r (nxt_rd)
  );

  prlm_ram #(.WIDTH(7), .DEPTH(TASK_DEPTH)) u_prv_ram (
    .clk     (clk),
    .we      (prv_we),
    .waddr   (prv_wa),
    .wdata   (prv_wd),
    .raddr   (id_a),
    .rdata_r (prv_rd)
  );

  prlm_ram #(.WIDTH(5), .DEPTH(TASK_DEPTH)) u_lvl_ram (
    .clk     (clk),
    .we      (lvl_we),
    .waddr   (id_a),
    .wdata   (in_r.task_prio),
    .raddr   (id_a),
    .rdata_r (lvl_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      in_r <= in_data;
    end
    if (cmd.disp) begin
      op_r   <= op_c;
      st_r   <= st_c;
      any_r  <= |bitmap_r;
      prio_r <= enc;
    end
    if (cmd.disp || cmd.tcap) begin
      lst_a_r <= lst_raddr;
    end
    if (cmd.tcap) begin
      p_r <= prv_rd;
      n_r <= nxt_rd;
    end
    if (cmd.lcap) begin
      h_r <= lh;
      t_r <= lt;
      c_r <= lc;
    end
    if (cmd.ncap) begin
      n_r <= nxt_rd;
    end
    if (cmd.res) begin
      out_r <= '{next_task: res_task,
                 next_prio: (op_r == prlm_pkg::OP_SCH && any_r) ? prio_r : 5'd0,
                 switch_needed: (op_r == prlm_pkg::OP_SCH) &&
                                (res_task != in_r.current_task),
                 status: st_r};
    end
  end

  assign res_task = (op_r == prlm_pkg::OP_SCH && any_r) ? h_r : prlm_pkg::NO_TASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r    <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res;
      if (cmd.wr1 && op_r == prlm_pkg::OP_INS) begin
        bitmap_r[lst_a_r] <= 1'b1;
        queued_r[id_a]    <= 1'b1;
      end else if (cmd.wr1 && op_r == prlm_pkg::OP_REM) begin
        queued_r[id_a] <= 1'b0;
        if (c_r == CW'(1)) begin
          bitmap_r[lst_a_r] <= 1'b0;
        end
      end
    end
  end

  assign sts.op       = cmd.disp ? op_c : op_r;
  assign sts.cnt_lt2  = lc < CW'(2);
  assign sts.cnt_zero = (c_r == '0);
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

>>> rtl/priority_ready_list_manager.sv
// ----------------------------------------------------------------------------
// priority_ready_list_manager
// Per-level doubly linked ready lists with bitmap lookup for scheduling.
// ----------------------------------------------------------------------------
//  channel  ports                    handshake
//  input    in_data                  start & !busy
//  result   out_data                 out_valid, one cycle
//
//  The result strobe follows acceptance once the registered RAM read round
//  trips (task links, then level list) and the link writes that the command
//  needs are done; two link writes share the next/prev link RAM write ports
//  in turn. busy stays high until the strobe cycle; reset clears the sequencer
//  state, ready bitmap, queued flags and out_valid, not the RAMs or data registers.
//  The receiver cannot stall; a result is valid for a single cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ready_list_manager #(
  parameter int PRIO_LEVELS = 32,
  parameter int MAX_TASKS   = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  prlm_pkg::in_t  in_data,
  output logic           out_valid,
  output prlm_pkg::out_t out_data
);

  prlm_pkg::ctl_cmd_t cmd;
  prlm_pkg::dp_sts_t  sts;

  prlm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  prlm_dp #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .MAX_TASKS   (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
